@@ sv/ilsu_pkg.sv @@
// Shared types, constants and codes for the Ising lattice spin update core.
`timescale 1ns / 1ps

package ilsu_pkg;

    // Lattice geometry
    localparam int MAX_SIDE  = 64;
    localparam int MIN_SIDE  = 3;
    localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W    = 12;
    localparam int SIDE_W    = 7;
    localparam int SQ_W      = 2 * SIDE_W - 1;

    // Field widths
    localparam int REQ_W     = 2;
    localparam int RND_W     = 16;
    localparam int THR_W     = 17;
    localparam int NUM_THR   = 5;
    localparam int THR_IDX_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_CNT_W = $clog2(ADDR_W);

    // Request codes (code 3 behaves as a read)
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_M4   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_M2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_ZERO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_P2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_P4   = 3'd6;

    // Threshold slots, ordered by spin times neighbor sum
    localparam logic [THR_IDX_W-1:0] THR_M4   = 3'd0;
    localparam logic [THR_IDX_W-1:0] THR_M2   = 3'd1;
    localparam logic [THR_IDX_W-1:0] THR_ZERO = 3'd2;
    localparam logic [THR_IDX_W-1:0] THR_P2   = 3'd3;
    localparam logic [THR_IDX_W-1:0] THR_P4   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;
    localparam logic [THR_W-1:0]  THR_RESET  = 17'd32768;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ADDR_W - 1);

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] site;
        logic              spin_value;
        logic [RND_W-1:0]  uniform_random;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] site_echo;
        logic              spin_now;
        logic              flipped;
        logic              on_boundary;
    } out_item_t;

    typedef struct packed {
        logic                            method_select;
        logic [SIDE_W-1:0]               grid_side;
        logic [NUM_THR-1:0][THR_W-1:0]   thresh;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_RD_CTR,
        ST_GET_CTR,
        ST_GET_W,
        ST_GET_E,
        ST_GET_N,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        RD_CENTER,
        RD_WEST,
        RD_EAST,
        RD_NORTH,
        RD_SOUTH
    } rd_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic    cap_in;
        logic    chk;
        logic    div_init;
        logic    div_step;
        rd_sel_t rd_sel;
        logic    cap_ctr;
        logic    cap_w;
        logic    cap_e;
        logic    cap_n;
        logic    decide;
        logic    wr_load;
        logic    out_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             in_range;
        logic             bnd;
    } ctrl_sts_t;

endpackage

@@ sv/ising_lattice_spin_update_core.sv @@
// Ising lattice spin update core: top level joining config, controller and datapath.
// A load or an out-of-range request goes from the check straight to the result; a read
// fetches the center spin; an in-range update runs the 12-step site/side division,
// reads the center and, when interior, the four neighbors through the one read port
// of the spin memory, then decides the flip. Items are taken one at a time, each result
// handed off before the next item. Reset (synchronous, aresetn low) clears control and
// config; the lattice is undefined until loaded and needs no clearing pass.
`timescale 1ns / 1ps

module ising_lattice_spin_update_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ilsu_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ilsu_pkg::out_item_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ilsu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ilsu_pkg::THR_W-1:0]     cfg_data
);

    ilsu_pkg::cfg_t      cfg;
    ilsu_pkg::ctrl_cmd_t cmd;
    ilsu_pkg::ctrl_sts_t sts;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    ilsu_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ilsu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ilsu_datapath u_dp (
        .aclk   (aclk),
        .s_data (s_data),
        .cfg    (cfg),
        .cmd    (cmd),
        .sts    (sts),
        .m_data (m_data)
    );

endmodule

@@ sv/ilsu_cfg_regs.sv @@
// Configuration register file: acceptance method, lattice side and flip thresholds.
`timescale 1ns / 1ps

module ilsu_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [ilsu_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [ilsu_pkg::THR_W-1:0]    wr_data,
    output ilsu_pkg::cfg_t                cfg
);

    ilsu_pkg::cfg_t cfg_reg;
    ilsu_pkg::cfg_t cfg_next;

    // Register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                ilsu_pkg::CFG_METHOD:   cfg_next.method_select = wr_data[0];
                ilsu_pkg::CFG_SIDE:     cfg_next.grid_side = wr_data[ilsu_pkg::SIDE_W-1:0];
                ilsu_pkg::CFG_THR_M4:   cfg_next.thresh[ilsu_pkg::THR_M4] = wr_data;
                ilsu_pkg::CFG_THR_M2:   cfg_next.thresh[ilsu_pkg::THR_M2] = wr_data;
                ilsu_pkg::CFG_THR_ZERO: cfg_next.thresh[ilsu_pkg::THR_ZERO] = wr_data;
                ilsu_pkg::CFG_THR_P2:   cfg_next.thresh[ilsu_pkg::THR_P2] = wr_data;
                ilsu_pkg::CFG_THR_P4:   cfg_next.thresh[ilsu_pkg::THR_P4] = wr_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.method_select <= 1'b0;
            cfg_reg.grid_side     <= ilsu_pkg::SIDE_RESET;
            for (int i = 0; i < ilsu_pkg::NUM_THR; i++) begin
                cfg_reg.thresh[i] <= ilsu_pkg::THR_RESET;
            end
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/ilsu_datapath.sv @@
// Datapath: request registers, site divider, spin memory, flip decision, result register.
`timescale 1ns / 1ps

module ilsu_datapath (
    input  logic                  aclk,
    input  ilsu_pkg::in_item_t    s_data,
    input  ilsu_pkg::cfg_t        cfg,
    input  ilsu_pkg::ctrl_cmd_t   cmd,
    output ilsu_pkg::ctrl_sts_t   sts,
    output ilsu_pkg::out_item_t   m_data
);

    // Request registers
    logic [ilsu_pkg::REQ_W-1:0]  req_reg;
    logic [ilsu_pkg::ADDR_W-1:0] site_reg;
    logic                        spin_in_reg;
    logic [ilsu_pkg::RND_W-1:0]  rnd_reg;

    // Divider registers: quotient is the row, remainder the column
    logic [ilsu_pkg::ADDR_W-1:0] quo_reg;
    logic [ilsu_pkg::SIDE_W-1:0] rem_reg;

    // Spin memory and captured spins
    logic                        mem [ilsu_pkg::DEPTH];
    logic                        rd_data_reg;
    logic                        ctr_reg;
    logic                        w_reg;
    logic                        e_reg;
    logic                        n_reg;
    logic                        in_range_reg;
    logic                        flip_reg;
    ilsu_pkg::out_item_t         out_reg;

    logic [ilsu_pkg::SIDE_W-1:0] side;
    logic [ilsu_pkg::SIDE_W-1:0] side_m1;
    logic [ilsu_pkg::SQ_W-1:0]   side_sq;
    logic                        in_range;
    logic [ilsu_pkg::SIDE_W-1:0] rem_shift;
    logic                        rem_ge;
    logic                        bnd;
    logic [ilsu_pkg::ADDR_W-1:0] side_ext;
    logic [ilsu_pkg::ADDR_W-1:0] rd_addr;
    logic [2:0]                  ones;
    logic [ilsu_pkg::THR_IDX_W-1:0] thr_idx;
    logic [ilsu_pkg::THR_W-1:0]  thr;
    logic                        flip;
    logic                        wr_en;
    logic                        wr_data;
    logic                        is_upd;
    logic                        is_load;
    ilsu_pkg::out_item_t         res;

    // Side in use, clamped to the supported range
    always_comb begin
        side = cfg.grid_side;
        if (cfg.grid_side < ilsu_pkg::SIDE_W'(ilsu_pkg::MIN_SIDE)) begin
            side = ilsu_pkg::SIDE_W'(ilsu_pkg::MIN_SIDE);
        end else if (cfg.grid_side > ilsu_pkg::SIDE_W'(ilsu_pkg::MAX_SIDE)) begin
            side = ilsu_pkg::SIDE_W'(ilsu_pkg::MAX_SIDE);
        end
    end

    assign side_m1  = side - 1'b1;
    assign side_sq  = ilsu_pkg::SQ_W'(side) * ilsu_pkg::SQ_W'(side);
    assign in_range = ilsu_pkg::SQ_W'(site_reg) < side_sq;
    assign side_ext = ilsu_pkg::ADDR_W'(side);

    // Restoring divider step: one quotient bit per cycle
    assign rem_shift = {rem_reg[ilsu_pkg::SIDE_W-2:0], quo_reg[ilsu_pkg::ADDR_W-1]};
    assign rem_ge    = rem_shift >= side;

    // Edge test on row and column
    assign bnd = (rem_reg == '0) || (rem_reg == side_m1) ||
                 (quo_reg == '0) || (quo_reg == ilsu_pkg::ADDR_W'(side_m1));

    // Read address select
    always_comb begin
        unique case (cmd.rd_sel)
            ilsu_pkg::RD_CENTER: rd_addr = site_reg;
            ilsu_pkg::RD_WEST:   rd_addr = site_reg - 1'b1;
            ilsu_pkg::RD_EAST:   rd_addr = site_reg + 1'b1;
            ilsu_pkg::RD_NORTH:  rd_addr = site_reg - side_ext;
            ilsu_pkg::RD_SOUTH:  rd_addr = site_reg + side_ext;
            default:             rd_addr = site_reg;
        endcase
    end

    // Flip decision; the south neighbor arrives straight from the memory
    assign ones    = 3'(w_reg) + 3'(e_reg) + 3'(n_reg) + 3'(rd_data_reg);
    assign thr_idx = ctr_reg ? ones : (3'd4 - ones);

    always_comb begin
        case (thr_idx)
            ilsu_pkg::THR_M4:   thr = cfg.thresh[ilsu_pkg::THR_M4];
            ilsu_pkg::THR_M2:   thr = cfg.thresh[ilsu_pkg::THR_M2];
            ilsu_pkg::THR_ZERO: thr = cfg.thresh[ilsu_pkg::THR_ZERO];
            ilsu_pkg::THR_P2:   thr = cfg.thresh[ilsu_pkg::THR_P2];
            default:            thr = cfg.thresh[ilsu_pkg::THR_P4];
        endcase
    end

    // Metropolis always accepts a non-positive energy product
    assign flip = (cfg.method_select && (thr_idx <= ilsu_pkg::THR_ZERO)) ||
                  (ilsu_pkg::THR_W'(rnd_reg) < thr);

    // Memory write: either a load or an accepted flip
    assign wr_en   = (cmd.wr_load && in_range) || (cmd.decide && flip);
    assign wr_data = cmd.wr_load ? spin_in_reg : ~ctr_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[site_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Request capture, divider, spin capture
    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            req_reg     <= s_data.req_type;
            site_reg    <= s_data.site;
            spin_in_reg <= s_data.spin_value;
            rnd_reg     <= s_data.uniform_random;
        end
        if (cmd.chk) begin
            in_range_reg <= in_range;
        end
        if (cmd.div_init) begin
            quo_reg <= site_reg;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[ilsu_pkg::ADDR_W-2:0], rem_ge};
            rem_reg <= rem_ge ? (rem_shift - side) : rem_shift;
        end
        if (cmd.cap_ctr) ctr_reg <= rd_data_reg;
        if (cmd.cap_w)   w_reg   <= rd_data_reg;
        if (cmd.cap_e)   e_reg   <= rd_data_reg;
        if (cmd.cap_n)   n_reg   <= rd_data_reg;
        if (cmd.decide)  flip_reg <= flip;
        if (cmd.out_load) out_reg <= res;
    end

    // Result assembly
    assign is_upd  = req_reg == ilsu_pkg::REQ_UPDATE;
    assign is_load = req_reg == ilsu_pkg::REQ_LOAD;

    always_comb begin
        res.site_echo   = site_reg;
        res.flipped     = is_upd && in_range_reg && !bnd && flip_reg;
        res.on_boundary = is_upd && (!in_range_reg || bnd);
        if (is_load) begin
            res.spin_now = in_range_reg && spin_in_reg;
        end else if (is_upd) begin
            res.spin_now = in_range_reg && (ctr_reg ^ (!bnd && flip_reg));
        end else begin
            res.spin_now = in_range_reg && ctr_reg;
        end
    end

    assign sts.req_type = req_reg;
    assign sts.in_range = in_range;
    assign sts.bnd      = bnd;
    assign m_data       = out_reg;

endmodule

@@ sv/ilsu_ctrl.sv @@
// Controller: request sequencing state machine and result valid flag.
`timescale 1ns / 1ps

module ilsu_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  ilsu_pkg::ctrl_sts_t  sts,
    output ilsu_pkg::ctrl_cmd_t  cmd
);

    ilsu_pkg::state_t                state_reg;
    ilsu_pkg::state_t                state_next;
    logic [ilsu_pkg::DIV_CNT_W-1:0]  div_cnt_reg;
    logic [ilsu_pkg::DIV_CNT_W-1:0]  div_cnt_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ilsu_pkg::ST_IDLE;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.rd_sel   = ilsu_pkg::RD_CENTER;
        unique case (state_reg)
            ilsu_pkg::ST_IDLE: begin
                cmd.cap_in = s_valid;
                if (s_valid) state_next = ilsu_pkg::ST_CHECK;
            end
            ilsu_pkg::ST_CHECK: begin
                cmd.chk      = 1'b1;
                cmd.div_init = 1'b1;
                if (sts.req_type == ilsu_pkg::REQ_LOAD) begin
                    cmd.wr_load = 1'b1;
                    state_next  = ilsu_pkg::ST_DONE;
                end else if (sts.req_type == ilsu_pkg::REQ_UPDATE) begin
                    state_next = sts.in_range ? ilsu_pkg::ST_DIV : ilsu_pkg::ST_DONE;
                end else begin
                    state_next = sts.in_range ? ilsu_pkg::ST_RD_CTR : ilsu_pkg::ST_DONE;
                end
            end
            ilsu_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == ilsu_pkg::DIV_LAST) begin
                    div_cnt_next = '0;
                    state_next   = ilsu_pkg::ST_RD_CTR;
                end
            end
            ilsu_pkg::ST_RD_CTR: begin
                cmd.rd_sel = ilsu_pkg::RD_CENTER;
                state_next = ilsu_pkg::ST_GET_CTR;
            end
            ilsu_pkg::ST_GET_CTR: begin
                cmd.cap_ctr = 1'b1;
                if (sts.req_type == ilsu_pkg::REQ_UPDATE && !sts.bnd) begin
                    cmd.rd_sel = ilsu_pkg::RD_WEST;
                    state_next = ilsu_pkg::ST_GET_W;
                end else begin
                    state_next = ilsu_pkg::ST_DONE;
                end
            end
            ilsu_pkg::ST_GET_W: begin
                cmd.cap_w  = 1'b1;
                cmd.rd_sel = ilsu_pkg::RD_EAST;
                state_next = ilsu_pkg::ST_GET_E;
            end
            ilsu_pkg::ST_GET_E: begin
                cmd.cap_e  = 1'b1;
                cmd.rd_sel = ilsu_pkg::RD_NORTH;
                state_next = ilsu_pkg::ST_GET_N;
            end
            ilsu_pkg::ST_GET_N: begin
                cmd.cap_n  = 1'b1;
                cmd.rd_sel = ilsu_pkg::RD_SOUTH;
                state_next = ilsu_pkg::ST_DECIDE;
            end
            ilsu_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ilsu_pkg::ST_DONE;
            end
            ilsu_pkg::ST_DONE: begin
                // Hand off once the result register is free or draining
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ilsu_pkg::ST_IDLE;
                end
            end
            default: state_next = ilsu_pkg::ST_IDLE;
        endcase
    end

    // Result valid flag
    assign m_valid_next = cmd.out_load || (m_valid_reg && !m_ready);

    assign s_ready = state_reg == ilsu_pkg::ST_IDLE;
    assign m_valid = m_valid_reg;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register loaded while holding an untaken result");

    // The flip write only happens for update requests
    a_decide_update: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |-> (sts.req_type == ilsu_pkg::REQ_UPDATE))
        else $error("flip decision for a non-update request");

    // Load writes only for load requests
    a_load_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_load |-> (sts.req_type == ilsu_pkg::REQ_LOAD))
        else $error("spin load for a non-load request");

    // Divider count rests at zero outside the division
    a_div_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ilsu_pkg::ST_DIV) |-> (div_cnt_reg == '0))
        else $error("divider count left nonzero");

    // No result is produced in the cycle right after a transfer in
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !cmd.out_load)
        else $error("result produced without processing");

endmodule

@@ test/ising_lattice_spin_update_core_tb.sv @@
// Self-checking testbench for the Ising lattice spin update core.
`timescale 1ns / 1ps

module ising_lattice_spin_update_core_tb;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 1850;
    localparam int MAX_REPORTS     = 10;

    // Index past the last register; writes to it must change nothing
    localparam logic [ilsu_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    // Unused request code, acts as a read
    localparam logic [ilsu_pkg::REQ_W-1:0]     REQ_UNUSED = 2'd3;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    ilsu_pkg::in_item_t             s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    ilsu_pkg::out_item_t            m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ilsu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ilsu_pkg::THR_W-1:0]     cfg_data  = '0;

    // Shadow lattice and registers of the block
    bit                          lattice_spin   [0:ilsu_pkg::DEPTH-1];
    bit                          lattice_loaded [0:ilsu_pkg::DEPTH-1];
    logic                        shadow_method = 1'b0;
    logic [ilsu_pkg::SIDE_W-1:0] shadow_side   = ilsu_pkg::SIDE_RESET;
    logic [ilsu_pkg::THR_W-1:0]  shadow_thr [0:ilsu_pkg::NUM_THR-1] =
        '{ilsu_pkg::THR_RESET, ilsu_pkg::THR_RESET, ilsu_pkg::THR_RESET,
          ilsu_pkg::THR_RESET, ilsu_pkg::THR_RESET};

    ilsu_pkg::out_item_t pending_spin_results [$];
    ilsu_pkg::out_item_t oldest_expected;
    int        mismatch_count = 0;
    int        requests_sent  = 0;
    int        cycle_count    = 0;
    int        hold_off_request = 0;
    bit        idle_on = 1'b1;

    ising_lattice_spin_update_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Side length actually used, clamped to the supported range
    function automatic int side_in_use();
        int n;
        n = int'(shadow_side);
        if (n < ilsu_pkg::MIN_SIDE) n = ilsu_pkg::MIN_SIDE;
        if (n > ilsu_pkg::MAX_SIDE) n = ilsu_pkg::MAX_SIDE;
        return n;
    endfunction

    function automatic bit is_interior(input int site, input int n);
        int row;
        int col;
        row = site / n;
        col = site % n;
        return (row > 0) && (row < n - 1) && (col > 0) && (col < n - 1);
    endfunction

    // Expected result of one request; updates the shadow lattice as the block would
    function automatic ilsu_pkg::out_item_t predict_spin_result(input ilsu_pkg::in_item_t req);
        ilsu_pkg::out_item_t res;
        int        n;
        int        site;
        int        ones;
        int        prod;
        int        slot;
        bit        in_range;
        bit        spin;
        bit        flip;
        n        = side_in_use();
        site     = int'(req.site);
        in_range = site < n * n;
        res      = '0;
        res.site_echo = req.site;
        case (req.req_type)
            ilsu_pkg::REQ_LOAD: begin
                if (in_range) begin
                    lattice_spin[site]   = req.spin_value;
                    lattice_loaded[site] = 1'b1;
                    res.spin_now         = req.spin_value;
                end
            end
            ilsu_pkg::REQ_UPDATE: begin
                if (!in_range) begin
                    res.on_boundary = 1'b1;
                end else if (!is_interior(site, n)) begin
                    res.on_boundary = 1'b1;
                    res.spin_now    = lattice_spin[site];
                end else begin
                    spin = lattice_spin[site];
                    ones = int'(lattice_spin[site - 1]) + int'(lattice_spin[site + 1])
                         + int'(lattice_spin[site - n]) + int'(lattice_spin[site + n]);
                    prod = spin ? (2 * ones - 4) : (4 - 2 * ones);
                    slot = (prod + 4) / 2;
                    flip = (shadow_method && prod <= 0)
                        || (int'(req.uniform_random) < int'(shadow_thr[slot]));
                    if (flip) begin
                        spin               = ~spin;
                        lattice_spin[site] = spin;
                        res.flipped        = 1'b1;
                    end
                    res.spin_now = spin;
                end
            end
            default: begin
                // read, and the unused code that acts as one
                if (in_range) res.spin_now = lattice_spin[site];
            end
        endcase
        return res;
    endfunction

    function automatic ilsu_pkg::in_item_t make_request(
        input logic [ilsu_pkg::REQ_W-1:0] code, input int site,
        input logic spin, input logic [ilsu_pkg::RND_W-1:0] rnd);
        ilsu_pkg::in_item_t r;
        r.req_type       = code;
        r.site           = site[ilsu_pkg::ADDR_W-1:0];
        r.spin_value     = spin;
        r.uniform_random = rnd;
        return r;
    endfunction

    function automatic logic rand_spin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [ilsu_pkg::RND_W-1:0] rand_rnd();
        return ilsu_pkg::RND_W'($urandom_range(0, 65535));
    endfunction

    // One request transfer; expectation queued at the accepting edge
    task automatic send_request(input ilsu_pkg::in_item_t item);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_spin_results.push_back(predict_spin_result(item));
        requests_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_spin_results.size() != 0) @(posedge aclk);
    endtask

    // Program every register, plus the unused index, once the block is idle
    task automatic program_registers(input logic [ilsu_pkg::THR_W-1:0] method_word,
                                     input logic [ilsu_pkg::THR_W-1:0] side_word,
                                     input logic [ilsu_pkg::THR_W-1:0] t_m4,
                                     input logic [ilsu_pkg::THR_W-1:0] t_m2,
                                     input logic [ilsu_pkg::THR_W-1:0] t_zero,
                                     input logic [ilsu_pkg::THR_W-1:0] t_p2,
                                     input logic [ilsu_pkg::THR_W-1:0] t_p4);
        logic [ilsu_pkg::THR_W-1:0]     image [0:7];
        logic [ilsu_pkg::CFG_IDX_W-1:0] idx;
        wait_for_results();
        image[ilsu_pkg::CFG_METHOD]   = method_word;
        image[ilsu_pkg::CFG_SIDE]     = side_word;
        image[ilsu_pkg::CFG_THR_M4]   = t_m4;
        image[ilsu_pkg::CFG_THR_M2]   = t_m2;
        image[ilsu_pkg::CFG_THR_ZERO] = t_zero;
        image[ilsu_pkg::CFG_THR_P2]   = t_p2;
        image[ilsu_pkg::CFG_THR_P4]   = t_p4;
        image[CFG_UNUSED]   = ilsu_pkg::THR_W'($urandom_range(0, (1 << ilsu_pkg::THR_W) - 1));
        for (int i = 0; i < 8; i++) begin
            idx = i[ilsu_pkg::CFG_IDX_W-1:0];
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= image[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (idx)
                ilsu_pkg::CFG_METHOD:   shadow_method = image[i][0];
                ilsu_pkg::CFG_SIDE:     shadow_side   = image[i][ilsu_pkg::SIDE_W-1:0];
                ilsu_pkg::CFG_THR_M4:   shadow_thr[ilsu_pkg::THR_M4]   = image[i];
                ilsu_pkg::CFG_THR_M2:   shadow_thr[ilsu_pkg::THR_M2]   = image[i];
                ilsu_pkg::CFG_THR_ZERO: shadow_thr[ilsu_pkg::THR_ZERO] = image[i];
                ilsu_pkg::CFG_THR_P2:   shadow_thr[ilsu_pkg::THR_P2]   = image[i];
                ilsu_pkg::CFG_THR_P4:   shadow_thr[ilsu_pkg::THR_P4]   = image[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Loads a random spin into a site that has never been written
    task automatic ensure_loaded(input int site);
        if (!lattice_loaded[site])
            send_request(make_request(ilsu_pkg::REQ_LOAD, site, rand_spin(), rand_rnd()));
    endtask

    task automatic issue_update(input int site, input logic [ilsu_pkg::RND_W-1:0] rnd);
        int n;
        n = side_in_use();
        if (site < n * n) begin
            ensure_loaded(site);
            if (is_interior(site, n)) begin
                ensure_loaded(site - 1);
                ensure_loaded(site + 1);
                ensure_loaded(site - n);
                ensure_loaded(site + n);
            end
        end
        send_request(make_request(ilsu_pkg::REQ_UPDATE, site, rand_spin(), rnd));
    endtask

    task automatic issue_read(input int site, input logic [ilsu_pkg::REQ_W-1:0] code);
        if (site < side_in_use() * side_in_use()) ensure_loaded(site);
        send_request(make_request(code, site, rand_spin(), rand_rnd()));
    endtask

    function automatic logic [ilsu_pkg::THR_W-1:0] pick_threshold();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return 17'd1;
            2: return 17'd65535;
            3: return 17'd65536;
            4: return ilsu_pkg::THR_W'($urandom_range(65537, 131071));
            default: return ilsu_pkg::THR_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Random fraction, often sitting right at a threshold
    function automatic logic [ilsu_pkg::RND_W-1:0] pick_random_value();
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 65535;
            2, 3: v = int'(shadow_thr[$urandom_range(0, ilsu_pkg::NUM_THR - 1)])
                    - int'($urandom_range(0, 1));
            default: v = $urandom_range(0, 65535);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[ilsu_pkg::RND_W-1:0];
    endfunction

    function automatic logic [ilsu_pkg::THR_W-1:0] pick_side_word();
        int s;
        case ($urandom_range(0, 19))
            0, 1: s = 64;
            2:    s = $urandom_range(0, 2);
            3:    s = $urandom_range(65, 127);
            4:    s = $urandom_range(13, 63);
            default: s = $urandom_range(3, 12);
        endcase
        return {10'($urandom_range(0, 1023)), s[ilsu_pkg::SIDE_W-1:0]};
    endfunction

    // Mostly interior updates on a loaded neighborhood, with reads, loads and strays
    task automatic random_request();
        int n;
        int area;
        int sel;
        int site;
        n    = side_in_use();
        area = n * n;
        sel  = $urandom_range(0, 99);
        if ($urandom_range(0, 4) != 0)
            site = $urandom_range(1, n - 2) * n + $urandom_range(1, n - 2);
        else
            site = $urandom_range(0, area - 1);
        if (sel < 60) begin
            issue_update(site, pick_random_value());
        end else if (sel < 72) begin
            issue_read(site, ilsu_pkg::REQ_READ);
        end else if (sel < 82) begin
            send_request(make_request(ilsu_pkg::REQ_LOAD, site, rand_spin(), rand_rnd()));
        end else if (sel < 92 && area < ilsu_pkg::DEPTH) begin
            // site past the active lattice, any request code
            site = $urandom_range(area, ilsu_pkg::DEPTH - 1);
            case ($urandom_range(0, 3))
                0: send_request(make_request(ilsu_pkg::REQ_LOAD, site, rand_spin(),
                                             rand_rnd()));
                1: issue_update(site, pick_random_value());
                2: issue_read(site, ilsu_pkg::REQ_READ);
                default: issue_read(site, REQ_UNUSED);
            endcase
        end else begin
            issue_read(site, REQ_UNUSED);
        end
    endtask

    // Result side: random stall per result, or a long hold-off on request
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_request > 0) begin
                stall = hold_off_request;
                hold_off_request = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_spin_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: site %0d spin %0b flipped %0b boundary %0b",
                             m_data.site_echo, m_data.spin_now, m_data.flipped,
                             m_data.on_boundary);
            end else begin
                oldest_expected = pending_spin_results.pop_front();
                if (m_data.site_echo !== oldest_expected.site_echo
                    || m_data.spin_now !== oldest_expected.spin_now
                    || m_data.flipped !== oldest_expected.flipped
                    || m_data.on_boundary !== oldest_expected.on_boundary) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected site %0d spin %0b flipped %0b boundary %0b,",
                                 oldest_expected.site_echo, oldest_expected.spin_now,
                                 oldest_expected.flipped, oldest_expected.on_boundary,
                                 " got site %0d spin %0b flipped %0b boundary %0b",
                                 m_data.site_echo, m_data.spin_now, m_data.flipped,
                                 m_data.on_boundary);
                end
            end
        end
    end

    // Reset values: side 64, Gibbs, all thresholds at one half
    task automatic test_reset_defaults();
        send_request(make_request(ilsu_pkg::REQ_LOAD, 65, 1'b1, 16'h0000));
        send_request(make_request(ilsu_pkg::REQ_LOAD, 64, 1'b0, 16'hFFFF));
        send_request(make_request(ilsu_pkg::REQ_LOAD, 66, 1'b1, 16'h0000));
        send_request(make_request(ilsu_pkg::REQ_LOAD, 1, 1'b0, 16'hFFFF));
        send_request(make_request(ilsu_pkg::REQ_LOAD, 129, 1'b1, 16'h0000));
        send_request(make_request(ilsu_pkg::REQ_UPDATE, 65, 1'b0, 16'h0000));
        send_request(make_request(ilsu_pkg::REQ_UPDATE, 65, 1'b1, 16'hFFFF));
        send_request(make_request(REQ_UNUSED, 65, 1'b0, 16'h1234));
        send_request(make_request(ilsu_pkg::REQ_LOAD, ilsu_pkg::DEPTH - 1, 1'b1, 16'hFFFF));
        send_request(make_request(ilsu_pkg::REQ_READ, ilsu_pkg::DEPTH - 1, 1'b0, 16'h0000));
        send_request(make_request(ilsu_pkg::REQ_UPDATE, ilsu_pkg::DEPTH - 1, 1'b1, 16'h0000));
    endtask

    // Side below minimum, Metropolis, extreme thresholds, sites past the lattice
    task automatic test_small_grid_cases();
        program_registers(17'd1, 17'd0, 17'd0, 17'd65536, 17'd131071, 17'd65535, 17'd1);
        send_request(make_request(ilsu_pkg::REQ_LOAD, 9, 1'b1, 16'h0000));
        send_request(make_request(ilsu_pkg::REQ_READ, ilsu_pkg::DEPTH - 1, 1'b1, 16'hFFFF));
        send_request(make_request(ilsu_pkg::REQ_UPDATE, 9, 1'b0, 16'h0000));
        send_request(make_request(ilsu_pkg::REQ_LOAD, 4, 1'b1, 16'h0000));
        send_request(make_request(ilsu_pkg::REQ_LOAD, 1, 1'b1, 16'h0000));
        send_request(make_request(ilsu_pkg::REQ_LOAD, 3, 1'b1, 16'h0000));
        send_request(make_request(ilsu_pkg::REQ_LOAD, 5, 1'b1, 16'h0000));
        send_request(make_request(ilsu_pkg::REQ_LOAD, 7, 1'b1, 16'h0000));
        // aligned with all neighbors, flips only below the tiny threshold
        send_request(make_request(ilsu_pkg::REQ_UPDATE, 4, 1'b0, 16'h0000));
        // now anti-aligned: Metropolis flips regardless of the random value
        send_request(make_request(ilsu_pkg::REQ_UPDATE, 4, 1'b0, 16'hFFFF));
    endtask

    // Side above maximum acts as the full lattice; site 4 becomes a top edge
    task automatic test_side_clamp();
        program_registers(17'h1FFFE, 17'h1FFFF, ilsu_pkg::THR_RESET, ilsu_pkg::THR_RESET,
                          ilsu_pkg::THR_RESET, ilsu_pkg::THR_RESET, ilsu_pkg::THR_RESET);
        send_request(make_request(ilsu_pkg::REQ_UPDATE, 4, 1'b1, 16'h0000));
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        program_registers(17'd0, 17'd5, 17'd40000, 17'd20000, 17'd32768, 17'd10000,
                          17'd5000);
        idle_on = 1'b0;
        hold_off_request = HOLD_OFF_CYCLES;
        repeat (12) random_request();
        wait_for_results();
        idle_on = 1'b1;
    endtask

    task automatic test_random_sweeps();
        int target;
        int burst;
        target = RANDOM_ITEMS;
        while (requests_sent < target) begin
            program_registers({16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1))},
                              pick_side_word(), pick_threshold(), pick_threshold(),
                              pick_threshold(), pick_threshold(), pick_threshold());
            idle_on = ($urandom_range(0, 3) != 0);
            burst = $urandom_range(60, 200);
            repeat (burst) begin
                if (requests_sent < target) random_request();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_small_grid_cases();
        test_side_clamp();
        test_output_backpressure();
        test_random_sweeps();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_spin_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
